[src/sjfk_pkg.sv]
// Shared types, constants and fixed-point helpers for the forward kinematics unit.
package sjfk_pkg;

	localparam int REG_BITS = 18;
	localparam int NUM_REGS = 6;
	localparam int IDX_BITS = 3;
	localparam int Q14_ONE  = 16384;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_D1 = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_A2 = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_A3 = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_D4 = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_D5 = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_D6 = 3'd5;

	// sine polynomial coefficients, Q30
	localparam logic [31:0] SC1 = 32'd1686629713;
	localparam logic [31:0] SC3 = 32'd693598668;
	localparam logic [31:0] SC5 = 32'd85569306;
	localparam logic [31:0] SC7 = 32'd5026995;
	localparam logic [31:0] SC9 = 32'd172272;

	typedef logic signed [15:0] q14_t;
	typedef logic signed [REG_BITS-1:0] len_t;
	typedef logic signed [39:0] pos_t;

	typedef struct packed {
		q14_t xx; q14_t xy; q14_t xz;
		q14_t yx; q14_t yy; q14_t yz;
		q14_t zx; q14_t zy; q14_t zz;
	} rot_t;

	typedef struct packed {
		q14_t s;
		q14_t c;
	} sc_t;

	// floor((v + 2^13) / 2^14)
	function automatic logic signed [39:0] round14(input logic signed [39:0] v);
		logic signed [39:0] t;
		t = v + 40'sd8192;
		return t >>> 14;
	endfunction

	function automatic q14_t clamp14(input logic signed [39:0] v);
		if (v > 40'sd16384) return 16'sd16384;
		if (v < -40'sd16384) return -16'sd16384;
		return v[15:0];
	endfunction

endpackage

[src/sjfk_sincos.sv]
// Pipelined quarter-wave sine and cosine of one angle (Horner, one step in stages 1 to 4).
module sjfk_sincos import sjfk_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic [ANGLE_BITS-1:0] angle,
	output sc_t                   sc
);
	localparam int NSTG = 7;

	logic [31:0] ph_s, phc_s;
	logic [1:0]  qs_s [NSTG], qc_s [NSTG];
	logic [31:0] ts_s [NSTG], tc_s [NSTG];

	assign ph_s  = {angle, {(32-ANGLE_BITS){1'b0}}};
	assign phc_s = ph_s + 32'h4000_0000;

	// fold into quarter wave
	function automatic logic [30:0] fold(input logic [31:0] p);
		logic [30:0] z;
		z = {1'b0, p[29:0]};
		if (p[30]) z = 31'h4000_0000 - z;
		return z;
	endfunction

	function automatic logic [31:0] hstep(input logic [31:0] k, input logic [30:0] z2,
			input logic [31:0] t);
		logic [63:0] m;
		m = {33'd0, z2} * {32'd0, t};
		return k - m[61:30];
	endfunction

	function automatic q14_t fin(input logic [1:0] q, input logic [30:0] z,
			input logic [31:0] t);
		logic [63:0] m;
		logic [33:0] s;
		logic [17:0] r;
		m = {33'd0, z} * {32'd0, t};
		s = m[63:30];
		r = 18'((s + 34'd32768) >> 16);
		if (r > 18'd16384) r = 18'd16384;
		return q[1] ? -$signed(r[15:0]) : $signed(r[15:0]);
	endfunction

	logic [30:0] zfs, zfc, zfs_s [NSTG], zfc_s [NSTG], z2fs_s [NSTG], z2fc_s [NSTG];
	logic [61:0] sqs, sqc;
	assign zfs = fold(ph_s);
	assign zfc = fold(phc_s);
	assign sqs = zfs * zfs;
	assign sqc = zfc * zfc;

	// stage 0: fold and square
	always_ff @(posedge clk) begin
		qs_s[0]   <= ph_s[31:30];
		qc_s[0]   <= phc_s[31:30];
		zfs_s[0]  <= zfs;
		zfc_s[0]  <= zfc;
		z2fs_s[0] <= sqs[60:30];
		z2fc_s[0] <= sqc[60:30];
		ts_s[0]   <= SC9;
		tc_s[0]   <= SC9;
	end

	// Horner stages 1 to 4; stages 5 and 6 only pass the values on
	for (genvar g = 1; g < NSTG; g++) begin : g_h
		logic [31:0] k;
		always_comb begin
			case (g)
				1: k = SC7;
				2: k = SC5;
				3: k = SC3;
				default: k = SC1;
			endcase
		end
		always_ff @(posedge clk) begin
			qs_s[g]   <= qs_s[g-1];
			qc_s[g]   <= qc_s[g-1];
			zfs_s[g]  <= zfs_s[g-1];
			zfc_s[g]  <= zfc_s[g-1];
			z2fs_s[g] <= z2fs_s[g-1];
			z2fc_s[g] <= z2fc_s[g-1];
			if (g <= 4) begin
				ts_s[g] <= hstep(k, z2fs_s[g-1], ts_s[g-1]);
				tc_s[g] <= hstep(k, z2fc_s[g-1], tc_s[g-1]);
			end else begin
				ts_s[g] <= ts_s[g-1];
				tc_s[g] <= tc_s[g-1];
			end
		end
	end

	assign sc.s = fin(qs_s[NSTG-1], zfs_s[NSTG-1], ts_s[NSTG-1]);
	assign sc.c = fin(qc_s[NSTG-1], zfc_s[NSTG-1], tc_s[NSTG-1]);
endmodule

[src/sjfk_link.sv]
// One link stage: twist, position update, then rotate by the joint angle (two registers).
module sjfk_link import sjfk_pkg::*; #(
	parameter int TWIST = 0
) (
	input  logic clk,
	input  rot_t r_in,
	input  pos_t px_in, py_in, pz_in,
	input  len_t lx,
	input  len_t lz,
	input  sc_t  sc,
	output rot_t r_out,
	output pos_t px_out, py_out, pz_out
);
	q14_t c0 [3], c1 [3], c2 [3];
	q14_t t0 [3], t1 [3];
	logic signed [39:0] p0 [3], po [3];
	q14_t r0_s1 [3], r1_s1 [3];
	pos_t p_s1 [3];
	sc_t  sc_s1;
	q14_t c0_o [3], c2_o [3];

	assign c0[0] = r_in.xx; assign c1[0] = r_in.xy; assign c2[0] = r_in.xz;
	assign c0[1] = r_in.yx; assign c1[1] = r_in.yy; assign c2[1] = r_in.yz;
	assign c0[2] = r_in.zx; assign c1[2] = r_in.zy; assign c2[2] = r_in.zz;
	assign p0[0] = px_in; assign p0[1] = py_in; assign p0[2] = pz_in;

	// twist and translation, stage 1
	for (genvar i = 0; i < 3; i++) begin : g_r
		q14_t n1, n2;
		logic signed [39:0] pr;
		logic signed [39:0] a, b;
		always_comb begin
			if (TWIST > 0) begin
				n1 = c2[i]; n2 = -c1[i];
			end else if (TWIST < 0) begin
				n1 = -c2[i]; n2 = c1[i];
			end else begin
				n1 = c1[i]; n2 = c2[i];
			end
			pr = 40'(c0[i] * lx) + 40'(n2 * lz);
		end
		always_ff @(posedge clk) begin
			r0_s1[i] <= c0[i];
			r1_s1[i] <= n1;
			t1[i]    <= n2;
			p_s1[i]  <= p0[i] + round14(pr);
		end
		// rotation by theta, stage 2
		always_comb begin
			a = 40'(sc_s1.c * r0_s1[i]) + 40'(sc_s1.s * r1_s1[i]);
			b = 40'(sc_s1.c * r1_s1[i]) - 40'(sc_s1.s * r0_s1[i]);
		end
		always_ff @(posedge clk) begin
			t0[i] <= clamp14(round14(a));
			c0_o[i] <= clamp14(round14(b));
			c2_o[i] <= t1[i];
			po[i] <= p_s1[i];
		end
	end

	always_ff @(posedge clk) sc_s1 <= sc;

	assign r_out = '{xx: t0[0], xy: c0_o[0], xz: c2_o[0],
		yx: t0[1], yy: c0_o[1], yz: c2_o[1],
		zx: t0[2], zy: c0_o[2], zz: c2_o[2]};
	assign px_out = po[0];
	assign py_out = po[1];
	assign pz_out = po[2];
endmodule

[src/six_joint_forward_kinematics_unit.sv]
// One pose accepted every cycle.
// The sine pipeline (seven register stages per joint) and six two-stage link units set latency.
// Each joint after the first has its angle delayed by registers to meet its link stage.
// Reset clears the valid chain and loads the offset registers with their defaults.
// The receiver cannot stall; each result shows for one cycle with done high.
// busy stays low: the pipeline takes a word every cycle.
module six_joint_forward_kinematics_unit import sjfk_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [15:0] joint1_angle, joint2_angle, joint3_angle,
	input  logic [15:0] joint4_angle, joint5_angle, joint6_angle,
	input  logic cfg_we,
	input  logic [IDX_BITS-1:0] cfg_idx,
	input  logic [REG_BITS-1:0] cfg_data,
	output logic done,
	output q14_t rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zy, rot_zz,
	output logic signed [18:0] pos_x, pos_y, pos_z
);
	localparam int SLAT = 7;
	localparam int LAT  = SLAT + 12 + 1;
	localparam logic signed [39:0] PLIM = 40'sd2 <<< POS_FRAC_BITS;

	len_t regs_q [NUM_REGS];
	logic [LAT-1:0] vld_s;
	logic [ANGLE_BITS-1:0] ang [6];
	logic [ANGLE_BITS-1:0] dly_s [6][10];

	assign busy = 1'b0;

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_D1] <= 18'sd10650;
			regs_q[REG_A2] <= -18'sd27853;
			regs_q[REG_A3] <= -18'sd25703;
			regs_q[REG_D4] <= 18'sd8736;
			regs_q[REG_D5] <= 18'sd6534;
			regs_q[REG_D6] <= 18'sd6527;
		end else if (cfg_we && cfg_idx < IDX_BITS'(NUM_REGS)) begin
			regs_q[cfg_idx] <= cfg_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else vld_s <= {vld_s[LAT-2:0], start};
	end

	// low angle bits only; zero-extended when the angle is wider than the port
	assign ang[0] = ANGLE_BITS'(joint1_angle);
	assign ang[1] = ANGLE_BITS'(joint2_angle);
	assign ang[2] = ANGLE_BITS'(joint3_angle);
	assign ang[3] = ANGLE_BITS'(joint4_angle);
	assign ang[4] = ANGLE_BITS'(joint5_angle);
	assign ang[5] = ANGLE_BITS'(joint6_angle);

	// angle delay lines and sine units
	sc_t sc [6];
	for (genvar k = 0; k < 6; k++) begin : g_j
		logic [ANGLE_BITS-1:0] a;
		always_ff @(posedge clk) begin
			dly_s[k][0] <= ang[k];
			for (int d = 1; d < 10; d++) dly_s[k][d] <= dly_s[k][d-1];
		end
		if (k == 0) begin : g_n
			assign a = ang[k];
		end else begin : g_d
			assign a = dly_s[k][2*k-1];
		end
		sjfk_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc (.clk(clk), .angle(a), .sc(sc[k]));
	end

	// link chain
	rot_t r [7];
	pos_t px [7], py [7], pz [7];
	len_t lx [6], lz [6];
	assign r[0] = '{xx: 16'sd16384, xy: '0, xz: '0, yx: '0, yy: 16'sd16384, yz: '0,
		zx: '0, zy: '0, zz: 16'sd16384};
	assign px[0] = '0; assign py[0] = '0; assign pz[0] = '0;
	assign lx[0] = '0; assign lz[0] = regs_q[REG_D1];
	assign lx[1] = '0; assign lz[1] = '0;
	assign lx[2] = regs_q[REG_A2]; assign lz[2] = '0;
	assign lx[3] = regs_q[REG_A3]; assign lz[3] = regs_q[REG_D4];
	assign lx[4] = '0; assign lz[4] = regs_q[REG_D5];
	assign lx[5] = '0; assign lz[5] = regs_q[REG_D6];

	for (genvar k = 0; k < 6; k++) begin : g_l
		localparam int TW = (k == 1 || k == 4) ? 1 : ((k == 5) ? -1 : 0);
		rot_t ri;
		pos_t xi, yi, zi;
		if (k == 0) begin : g_f
			// wait for the sine pipeline, hold identity inputs
			assign ri = r[0]; assign xi = px[0]; assign yi = py[0]; assign zi = pz[0];
		end else begin : g_c
			assign ri = r[k]; assign xi = px[k]; assign yi = py[k]; assign zi = pz[k];
		end
		sjfk_link #(.TWIST(TW)) u_l (.clk(clk), .r_in(ri), .px_in(xi), .py_in(yi),
			.pz_in(zi), .lx(lx[k]), .lz(lz[k]), .sc(sc[k]), .r_out(r[k+1]),
			.px_out(px[k+1]), .py_out(py[k+1]), .pz_out(pz[k+1]));
	end

	function automatic logic signed [18:0] sat(input pos_t v);
		if (v > PLIM) return 19'(PLIM);
		if (v < -PLIM) return 19'(-PLIM);
		return v[18:0];
	endfunction

	// output register
	rot_t ro_q;
	logic signed [18:0] xo_q, yo_q, zo_q;
	always_ff @(posedge clk) begin
		ro_q <= r[6];
		xo_q <= sat(px[6]);
		yo_q <= sat(py[6]);
		zo_q <= sat(pz[6]);
	end
	assign done = vld_s[LAT-1];
	assign rot_xx = ro_q.xx; assign rot_xy = ro_q.xy; assign rot_xz = ro_q.xz;
	assign rot_yx = ro_q.yx; assign rot_yy = ro_q.yy; assign rot_yz = ro_q.yz;
	assign rot_zx = ro_q.zx; assign rot_zy = ro_q.zy; assign rot_zz = ro_q.zz;
	assign pos_x = xo_q; assign pos_y = yo_q; assign pos_z = zo_q;

	// checks
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done) else $error("lost word");
	a_nob: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rot_xx <= 16'sd16384 && rot_xx >= -16'sd16384)) else $error("rot range");
endmodule
